// ----- rtl/fpsa_pkg.sv -----
package fpsa_pkg;

   // Field and register widths
   localparam int DELTA_W    = 24;
   localparam int FP_W       = 20;
   localparam int TOL_W      = 16;
   localparam int ACC_W      = 25;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Overflow limit is eight frame periods: a shift by three
   localparam int OVF_SHIFT = 3;
   localparam int FP8_W     = FP_W + OVF_SHIFT;

   localparam logic [COUNT_W-1:0] UPDATE_LIMIT = 4'd8;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_TOLERANCE = 2'd2;

   // Register defaults
   localparam logic [FP_W-1:0]  RESET_FRAME_PERIOD   = 20'd16666;
   localparam logic [FP_W-1:0]  RESET_REFRESH_PERIOD = 20'd16666;
   localparam logic [TOL_W-1:0] RESET_SNAP_TOLERANCE = 16'd200;

   // Sequencer states
   typedef enum logic [12:0] {
      S_IDLE      = 13'h0001,
      S_DIFF      = 13'h0002,
      S_CLAMP     = 13'h0004,
      S_SNAP_INIT = 13'h0008,
      S_SNAP      = 13'h0010,
      S_SNAP_FIX  = 13'h0020,
      S_SUM       = 13'h0040,
      S_DIV       = 13'h0080,
      S_AVG       = 13'h0100,
      S_ACCUM     = 13'h0200,
      S_RCHK      = 13'h0400,
      S_COUNT     = 13'h0800,
      S_DONE      = 13'h1000
   } state_type;

endpackage

// ----- rtl/frame_pacer_snap_average_top.sv -----
// Sequence per beat: difference, clamp, snap probes (one per refresh multiple, stopping on a hit
//   or after SNAP_MULTIPLES), history sum, then for a depth that is not a power of two a reciprocal
//   quotient followed by the remainder, then average, accumulate, resync check and update count.
// Throughput: one beat in flight; req_ready returns once the result is in the output register.
//   All add/subtract steps share one unit, one operation per cycle.
// Reset: synchronous, active high; restores register defaults, fills history, arms resync.
module frame_pacer_snap_average_top
   import fpsa_pkg::*;
#(
   parameter int HISTORY_DEPTH  = 4,
   parameter int SNAP_MULTIPLES = 8,
   parameter int TIME_WIDTH     = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_WIDTH-1:0] req_timestamp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_update_count,
   output logic                  rsp_resynced,
   output logic [DELTA_W-1:0]    rsp_smoothed_delta,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int W        = TIME_WIDTH;
   localparam int IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int REM_W    = IDX_W;
   localparam int SUM_W    = DELTA_W + IDX_W;
   localparam int CNT_W    = $clog2(SUM_W + 1);
   localparam bit HIST_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;

   // Reciprocal of the depth, exact for every sum below 2^SUM_W
   localparam int RECIP_SH = SUM_W + IDX_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
   localparam logic [SUM_W:0]   RECIP     = (SUM_W + 1)'(RECIP_FULL);
   localparam logic [REM_W-1:0] HIST_D_LO = REM_W'(HISTORY_DEPTH);

   localparam logic [CNT_W-1:0] MULT_LAST = CNT_W'(SNAP_MULTIPLES);
   localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(HISTORY_DEPTH - 1);
   localparam logic [REM_W:0]   HIST_REM  = (REM_W + 1)'(HISTORY_DEPTH);

   // Control and state registers
   state_type state_ff, state_in;
   logic [FP_W-1:0]  frame_period_ff, frame_period_in;
   logic [FP_W-1:0]  refresh_period_ff, refresh_period_in;
   logic [TOL_W-1:0] snap_tol_ff, snap_tol_in;
   logic [W-1:0]     prev_time_ff, prev_time_in;
   logic [REM_W-1:0] arem_ff, arem_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             pending_ff, pending_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [W-1:0]       now_ff, now_in;
   logic [W-1:0]       wk_ff, wk_in;
   logic [DELTA_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DELTA_W-1:0] q_ff, q_in;
   logic [REM_W-1:0]   mod_ff, mod_in;
   logic [SUM_W-1:0]   div_ff, div_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               resync_ff, resync_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_resync_ff, rsp_resync_in;
   logic [DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;

   // Shared unit and history
   logic [W-1:0]       alu_a, alu_b, alu_y;
   logic               alu_sub, alu_borrow;
   logic               hist_shift;
   logic [DELTA_W-1:0] hist_data, hist_rd;

   // Helpers
   logic [FP_W-1:0]    fp_eff;
   logic [FP8_W-1:0]   fp8;
   logic [W-1:0]       wk_abs;
   logic               snap_hit;
   logic [REM_W:0]     rem_acc, rem_wrap;
   logic               avg_carry;
   logic [2*SUM_W:0]   recip_prod;
   logic [DELTA_W-1:0] recip_q;
   logic [REM_W-1:0]   recip_rem;

   fpsa_alu #(.W(W)) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .y      (alu_y),
      .borrow (alu_borrow)
   );

   fpsa_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (hist_shift),
      .shift_data (hist_data),
      .rd_idx     (cnt_ff[IDX_W-1:0]),
      .rd_data    (hist_rd)
   );

   // Zero frame period acts as one
   assign fp_eff = (frame_period_ff == '0) ? FP_W'(1) : frame_period_ff;
   assign fp8    = {fp_eff, {OVF_SHIFT{1'b0}}};

   // Snap test on the running residue delta - k * refresh
   assign wk_abs   = wk_ff[W-1] ? (W'(0) - wk_ff) : wk_ff;
   assign snap_hit = wk_abs < W'(snap_tol_ff);

   // Quotient by reciprocal, remainder from low bits, remainder carry
   assign recip_prod = {{(SUM_W + 1){1'b0}}, div_ff} * {{SUM_W{1'b0}}, RECIP};
   assign recip_q    = recip_prod[RECIP_SH +: DELTA_W];
   assign recip_rem  = div_ff[REM_W-1:0] - REM_W'(q_ff[REM_W-1:0] * HIST_D_LO);
   assign rem_acc    = {1'b0, arem_ff} + {1'b0, mod_ff};
   assign avg_carry  = rem_acc >= HIST_REM;
   assign rem_wrap   = avg_carry ? (rem_acc - HIST_REM) : rem_acc;

   // Operand select for the shared unit
   always_comb begin
      alu_a   = wk_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_DIFF: begin
            alu_a   = now_ff;
            alu_b   = prev_time_ff;
            alu_sub = 1'b1;
         end
         S_CLAMP: begin
            alu_a   = W'(fp8);
            alu_b   = wk_ff;
            alu_sub = 1'b1;
         end
         S_SNAP_INIT: begin
            alu_a   = W'(d_ff);
            alu_b   = W'(refresh_period_ff);
            alu_sub = 1'b1;
         end
         S_SNAP: begin
            alu_a   = wk_ff;
            alu_b   = W'(refresh_period_ff);
            alu_sub = 1'b1;
         end
         S_SNAP_FIX: begin
            alu_a   = W'(d_ff);
            alu_b   = wk_ff;
            alu_sub = 1'b1;
         end
         S_SUM: begin
            alu_a = wk_ff;
            alu_b = W'(hist_rd);
         end
         S_AVG: begin
            alu_a = W'(q_ff);
            alu_b = W'(avg_carry);
         end
         S_ACCUM: begin
            alu_a = W'(acc_ff);
            alu_b = W'(q_ff);
         end
         S_RCHK: begin
            alu_a   = W'(fp8);
            alu_b   = W'(acc_ff);
            alu_sub = 1'b1;
         end
         S_COUNT: begin
            alu_a   = W'(acc_ff);
            alu_b   = W'(fp_eff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = wk_ff;
         end
      endcase
   end

   // Sequencer and next-state values
   always_comb begin
      state_in          = state_ff;
      frame_period_in   = frame_period_ff;
      refresh_period_in = refresh_period_ff;
      snap_tol_in       = snap_tol_ff;
      prev_time_in      = prev_time_ff;
      arem_in           = arem_ff;
      acc_in            = acc_ff;
      pending_in        = pending_ff;
      now_in            = now_ff;
      wk_in             = wk_ff;
      d_in              = d_ff;
      cnt_in            = cnt_ff;
      q_in              = q_ff;
      mod_in            = mod_ff;
      div_in            = div_ff;
      count_in          = count_ff;
      resync_in         = resync_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_count_in      = rsp_count_ff;
      rsp_resync_in     = rsp_resync_ff;
      rsp_delta_in      = rsp_delta_ff;
      hist_shift        = 1'b0;
      hist_data         = d_ff;

      // Register writes
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_PERIOD:   frame_period_in   = csr_wdata[FP_W-1:0];
            CSR_REFRESH_PERIOD: refresh_period_in = csr_wdata[FP_W-1:0];
            CSR_SNAP_TOLERANCE: snap_tol_in       = csr_wdata[TOL_W-1:0];
            default:            snap_tol_in       = snap_tol_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_timestamp;
               state_in = S_DIFF;
            end
         end
         // Wrapped time difference
         S_DIFF: begin
            wk_in        = alu_y;
            prev_time_in = now_ff;
            state_in     = S_CLAMP;
         end
         // Negative -> 0, above eight periods -> one period
         S_CLAMP: begin
            if (wk_ff[W-1]) begin
               d_in = '0;
            end else if (alu_borrow) begin
               d_in = DELTA_W'(fp_eff);
            end else begin
               d_in = wk_ff[DELTA_W-1:0];
            end
            state_in = S_SNAP_INIT;
         end
         S_SNAP_INIT: begin
            wk_in    = alu_y;
            cnt_in   = CNT_W'(1);
            state_in = S_SNAP;
         end
         // One refresh multiple per cycle
         S_SNAP: begin
            if (snap_hit) begin
               state_in = S_SNAP_FIX;
            end else if (cnt_ff == MULT_LAST) begin
               hist_shift = 1'b1;
               hist_data  = d_ff;
               wk_in      = '0;
               cnt_in     = '0;
               state_in   = S_SUM;
            end else begin
               wk_in  = alu_y;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         // Multiple = delta - residue
         S_SNAP_FIX: begin
            hist_shift = 1'b1;
            hist_data  = alu_y[DELTA_W-1:0];
            wk_in      = '0;
            cnt_in     = '0;
            state_in   = S_SUM;
         end
         // Sum one history entry per cycle
         S_SUM: begin
            wk_in  = alu_y;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == SUM_LAST) begin
               if (HIST_POW2) begin
                  q_in     = alu_y[SUM_W-1:IDX_W];
                  mod_in   = alu_y[IDX_W-1:0];
                  state_in = S_AVG;
               end else begin
                  div_in   = alu_y[SUM_W-1:0];
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
            end
         end
         // Quotient first, then the remainder from its low bits
         S_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == '0) begin
               q_in = recip_q;
            end else begin
               mod_in   = recip_rem;
               state_in = S_AVG;
            end
         end
         // Fold in carried remainder
         S_AVG: begin
            q_in     = alu_y[DELTA_W-1:0];
            arem_in  = rem_wrap[REM_W-1:0];
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            acc_in   = alu_y[ACC_W-1:0];
            state_in = S_RCHK;
         end
         // Resync on overflow or first frame
         S_RCHK: begin
            count_in  = '0;
            resync_in = 1'b0;
            if (alu_borrow || pending_ff) begin
               acc_in     = '0;
               pending_in = 1'b0;
               resync_in  = 1'b1;
            end
            state_in = S_COUNT;
         end
         // Remove whole periods, at most eight
         S_COUNT: begin
            if (!alu_borrow) begin
               acc_in   = alu_y[ACC_W-1:0];
               count_in = count_ff + COUNT_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_resync_in = resync_ff;
               rsp_delta_in  = q_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         frame_period_ff   <= RESET_FRAME_PERIOD;
         refresh_period_ff <= RESET_REFRESH_PERIOD;
         snap_tol_ff       <= RESET_SNAP_TOLERANCE;
         prev_time_ff      <= '0;
         arem_ff           <= '0;
         acc_ff            <= '0;
         pending_ff        <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         frame_period_ff   <= frame_period_in;
         refresh_period_ff <= refresh_period_in;
         snap_tol_ff       <= snap_tol_in;
         prev_time_ff      <= prev_time_in;
         arem_ff           <= arem_in;
         acc_ff            <= acc_in;
         pending_ff        <= pending_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Working and output payload
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      wk_ff         <= wk_in;
      d_ff          <= d_in;
      cnt_ff        <= cnt_in;
      q_ff          <= q_in;
      mod_ff        <= mod_in;
      div_ff        <= div_in;
      count_ff      <= count_in;
      resync_ff     <= resync_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_resync_ff <= rsp_resync_in;
      rsp_delta_ff  <= rsp_delta_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_update_count   = rsp_count_ff;
   assign rsp_resynced       = rsp_resync_ff;
   assign rsp_smoothed_delta = rsp_delta_ff;

endmodule

// ----- rtl/fpsa_alu.sv -----
// Shared add/subtract unit; borrow flags a < b on subtract
module fpsa_alu #(
   parameter int W = 48
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] y,
   output logic         borrow
);

   logic [W-1:0] b_sel;
   logic [W:0]   total;

   assign b_sel  = sub ? ~b : b;
   assign total  = {1'b0, a} + {1'b0, b_sel} + {{W{1'b0}}, sub};
   assign y      = total[W-1:0];
   assign borrow = sub & ~total[W];

endmodule

// ----- rtl/fpsa_hist.sv -----
// Delta history shift line, oldest at entry 0, with one indexed read tap
module fpsa_hist
   import fpsa_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic [DELTA_W-1:0]         shift_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   output logic [DELTA_W-1:0]         rd_data
);

   logic [DELTA_W-1:0] hist_ff [DEPTH];
   logic [DELTA_W-1:0] hist_in [DEPTH];

   // Shift toward entry 0, new delta enters at the top
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (shift_en) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i + 1];
         end
         hist_in[DEPTH-1] = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= DELTA_W'(RESET_FRAME_PERIOD);
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   assign rd_data = hist_ff[rd_idx];

endmodule

// ----- rtl/fpsa_checker.sv -----
// Port-level checks for the frame pacer
module fpsa_checker
   import fpsa_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COUNT_W-1:0] rsp_update_count,
   input logic               rsp_resynced,
   input logic [DELTA_W-1:0] rsp_smoothed_delta
);

   // Accumulator never holds more than eight periods
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_update_count <= UPDATE_LIMIT)
      else $error("update count above eight");

   // A resync empties the accumulator, so no updates run
   a_resync_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resynced |-> rsp_update_count == '0)
      else $error("resync beat carries updates");

   // One beat in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_update_count)
         && $stable(rsp_resynced) && $stable(rsp_smoothed_delta))
      else $error("stalled result beat changed");

endmodule

bind frame_pacer_snap_average_top fpsa_checker u_fpsa_checker (.*);

// ----- dv/tb_frame_pacer_snap_average_top.sv -----
module tb_frame_pacer_snap_average_top;
   import fpsa_pkg::*;

   localparam int STAMP_W       = 48;
   localparam int DEPTH         = 4;
   localparam int MULTIPLES     = 8;
   localparam int PHASE_ITEMS   = 205;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_START    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int BUSY_START    = 12000;
   localparam int BUSY_CYCLES   = 6000;

   typedef struct {
      logic [COUNT_W-1:0] update_count;
      logic               resynced;
      logic [DELTA_W-1:0] smoothed_delta;
   } pacing_type;

   // Pacing predictor plus the queue of results still owed by the block
   class pacing_scoreboard;
      logic [FP_W-1:0]    frame_ticks;
      logic [FP_W-1:0]    refresh_ticks;
      logic [TOL_W-1:0]   snap_window;
      logic [STAMP_W-1:0] prev_vsync;
      logic [DELTA_W-1:0] recent_deltas[DEPTH];
      logic [63:0]        mean_carry;
      logic [63:0]        step_total;
      bit                 resync_armed;
      pacing_type         pacing_due[$];
      int                 errors;

      function new();
         frame_ticks   = RESET_FRAME_PERIOD;
         refresh_ticks = RESET_REFRESH_PERIOD;
         snap_window   = RESET_SNAP_TOLERANCE;
         prev_vsync    = '0;
         foreach (recent_deltas[i]) recent_deltas[i] = DELTA_W'(RESET_FRAME_PERIOD);
         mean_carry    = 0;
         step_total    = 0;
         resync_armed  = 1'b1;
         errors        = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_FRAME_PERIOD:   frame_ticks   = value[FP_W-1:0];
            CSR_REFRESH_PERIOD: refresh_ticks = value[FP_W-1:0];
            CSR_SNAP_TOLERANCE: snap_window   = value[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the pacing result for one accepted vsync beat
      function void note_timestamp(logic [STAMP_W-1:0] stamp);
         logic [STAMP_W-1:0] raw;
         logic [63:0]        period, gap, snapped, multiple, miss, total, mean;
         bit                 hit;
         pacing_type         due;
         period = (frame_ticks == 0) ? 64'd1 : 64'(frame_ticks);
         raw = stamp - prev_vsync;
         prev_vsync = stamp;
         // Backward steps count as zero, runaway gaps as one frame
         if (raw[STAMP_W-1])
            gap = 0;
         else if (64'(raw) > period * 8)
            gap = period;
         else
            gap = 64'(raw);
         // First refresh multiple strictly inside the window wins
         snapped = gap;
         hit = 1'b0;
         for (int k = 1; k <= MULTIPLES; k++) begin
            multiple = 64'(refresh_ticks) * k;
            miss = (gap >= multiple) ? gap - multiple : multiple - gap;
            if (!hit && miss < 64'(snap_window)) begin
               snapped = multiple;
               hit = 1'b1;
            end
         end
         for (int i = 0; i < DEPTH - 1; i++) recent_deltas[i] = recent_deltas[i+1];
         recent_deltas[DEPTH-1] = snapped[DELTA_W-1:0];
         total = 0;
         foreach (recent_deltas[i]) total += 64'(recent_deltas[i]);
         // Average with the remainder carried into later frames
         mean = total / DEPTH;
         mean_carry += total % DEPTH;
         mean += mean_carry / DEPTH;
         mean_carry = mean_carry % DEPTH;
         mean = mean & 64'hFF_FFFF;
         step_total += mean;
         if (step_total > period * 8) resync_armed = 1'b1;
         due.resynced = resync_armed;
         if (resync_armed) begin
            step_total = 0;
            resync_armed = 1'b0;
         end
         due.update_count   = COUNT_W'(step_total / period);
         due.smoothed_delta = mean[DELTA_W-1:0];
         step_total = (step_total % period) & 64'h1FF_FFFF;
         pacing_due.push_back(due);
      endfunction

      function void check_pacing(logic [COUNT_W-1:0] update_count, logic resynced,
                                 logic [DELTA_W-1:0] smoothed_delta);
         pacing_type want;
         if (pacing_due.size() == 0) begin
            $display("%0t: unexpected result: update_count %0d resynced %0b delta %0d",
                     $time, update_count, resynced, smoothed_delta);
            errors++;
            return;
         end
         want = pacing_due.pop_front();
         if (want.update_count !== update_count) begin
            $display("%0t: update_count expected %0d actual %0d",
                     $time, want.update_count, update_count);
            errors++;
         end
         if (want.resynced !== resynced) begin
            $display("%0t: resynced expected %0b actual %0b", $time, want.resynced, resynced);
            errors++;
         end
         if (want.smoothed_delta !== smoothed_delta) begin
            $display("%0t: smoothed_delta expected %0d actual %0d",
                     $time, want.smoothed_delta, smoothed_delta);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [STAMP_W-1:0]    req_timestamp = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COUNT_W-1:0]    rsp_update_count;
   logic                  rsp_resynced;
   logic [DELTA_W-1:0]    rsp_smoothed_delta;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pacing_scoreboard   sb;
   logic [STAMP_W-1:0] last_stamp = '0;
   int                 ready_cycle = 0;

   frame_pacer_snap_average_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_update_count   (rsp_update_count),
      .rsp_resynced       (rsp_resynced),
      .rsp_smoothed_delta (rsp_smoothed_delta),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offer one vsync beat, maybe after an idle gap, and hold it until taken
   task automatic send_timestamp(input logic [STAMP_W-1:0] stamp, input bit may_idle);
      int unsigned gap;
      gap = 0;
      if (may_idle && $urandom_range(99) < 18) gap = $urandom_range(1, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_timestamp(stamp);
      last_stamp = stamp;
   endtask

   // Drain everything in flight, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pacing_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_pacing(input logic [FP_W-1:0] frame, input logic [FP_W-1:0] refresh,
                                 input logic [TOL_W-1:0] window);
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_PERIOD;
      csr_wdata <= CSR_DATA_W'(frame);
      @(posedge clock);
      csr_index <= CSR_REFRESH_PERIOD;
      csr_wdata <= CSR_DATA_W'(refresh);
      @(posedge clock);
      csr_index <= CSR_SNAP_TOLERANCE;
      csr_wdata <= CSR_DATA_W'(window);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(CSR_FRAME_PERIOD, CSR_DATA_W'(frame));
      sb.set_register(CSR_REFRESH_PERIOD, CSR_DATA_W'(refresh));
      sb.set_register(CSR_SNAP_TOLERANCE, CSR_DATA_W'(window));
   endtask

   // Mostly refresh-locked cadence with jitter around the snap window, plus noise
   function automatic logic [STAMP_W-1:0] pick_stamp(input logic [STAMP_W-1:0] prior);
      int unsigned sel, mult;
      longint      span, slack;
      logic [63:0] wide;
      sel = $urandom_range(99);
      slack = longint'(sb.snap_window) + 2;
      if (sel < 72) begin
         mult = ($urandom_range(9) == 0) ? MULTIPLES : $urandom_range(1, MULTIPLES);
         span = longint'(sb.refresh_ticks) * mult
                + longint'($urandom_range(0, 32'(2 * slack))) - slack;
         return prior + span[STAMP_W-1:0];
      end
      if (sel < 80) return prior + $urandom_range(0, 10 * sb.frame_ticks + 10);
      if (sel < 87) return prior - $urandom_range(1, 200000);
      if (sel < 94) begin
         wide = {$urandom, $urandom};
         return wide[STAMP_W-1:0];
      end
      return prior + $urandom_range(0, 3);
   endfunction

   // Result side: check every beat, stall at random, one long hold-off, one long always-ready stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_pacing(rsp_update_count, rsp_resynced, rsp_smoothed_delta);
         ready_cycle <= ready_cycle + 1;
         if (ready_cycle >= HOLD_START && ready_cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (ready_cycle >= BUSY_START && ready_cycle < BUSY_START + BUSY_CYCLES)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 18);
      end
   end

   // Watchdog on cycles with no beat on either channel
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("** frame_pacer_snap_average_top: FAILED **");
      $finish;
   end

   initial begin
      logic [STAMP_W-1:0] directed[$];
      logic [FP_W-1:0]    frame, refresh;
      logic [TOL_W-1:0]   window;
      sb = new();
      // Defaults: first frame resync, snap edges, 8-period limit, backward step,
      // wraps of the time counter, a run of eight-period frames
      directed = '{48'd0, 48'd16666, 48'd33531, 48'd50397, 48'd66864, 48'd100196,
                   48'd233524, 48'd366853, 48'd500481, 48'd500476, 48'd550474,
                   48'd683802, 48'd817130, 48'd950458,
                   48'hFFFF_FFFF_FF00, 48'h0000_0000_0010, 48'hFFFF_FFFF_FFFF,
                   48'h0000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                   48'h8000_0000_4112, 48'h8000_0000_8224, 48'h8000_0000_C336};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_timestamp(directed[i], 1'b1);

      for (int phase = 0; phase < 7; phase++) begin
         if (phase != 0) begin
            settle();
            case (phase)
               1: begin frame = 20'd1;      refresh = 20'd1;      window = 16'd0;     end
               2: begin frame = 20'hFFFFF;  refresh = 20'hFFFFF;  window = 16'hFFFF;  end
               3: begin frame = 20'd0;      refresh = 20'd0;      window = 16'd500;   end
               4: begin frame = 20'd16666;  refresh = 20'd8333;   window = 16'd300;   end
               5: begin
                  frame   = FP_W'($urandom_range(1000, 200000));
                  refresh = FP_W'(32'(frame) / $urandom_range(1, 3));
                  window  = TOL_W'($urandom_range(0, 2000));
               end
               default: begin frame = 20'd33333; refresh = 20'd16667; window = 16'hFFFF; end
            endcase
            program_pacing(frame, refresh, window);
         end
         // the third phase sends back to back
         repeat (PHASE_ITEMS) send_timestamp(pick_stamp(last_stamp), phase != 2);
      end

      settle();
      if (sb.errors == 0)
         $display("** frame_pacer_snap_average_top: PASSED **");
      else
         $display("** frame_pacer_snap_average_top: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fpsa_pkg.sv
rtl/fpsa_alu.sv
rtl/fpsa_hist.sv
rtl/frame_pacer_snap_average_top.sv
rtl/fpsa_checker.sv
dv/tb_frame_pacer_snap_average_top.sv
